>>> rtl/tcw_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_pkg: text console writer shared definitions
// Field types, operation codes and character codes used by the channel
// interfaces and the console engine.
// ---------------------------------------------------------------------------
package tcw_pkg;

  typedef logic [1:0]  opcode_t;
  typedef logic [7:0]  char_t;
  typedef logic [10:0] cell_index_t;
  typedef logic [7:0]  attr_t;
  typedef logic [15:0] cell_t;
  typedef logic [6:0]  cursor_col_t;
  typedef logic [4:0]  cursor_row_t;
  typedef logic [10:0] cursor_offset_t;

  localparam opcode_t OP_PUT   = 2'd0;
  localparam opcode_t OP_CLEAR = 2'd1;
  localparam opcode_t OP_READ  = 2'd2;

  localparam char_t CH_NEWLINE   = 8'd10;
  localparam char_t CH_BACKSPACE = 8'd8;
  localparam char_t CH_BLANK     = 8'h20;

  localparam attr_t RESET_ATTR = 8'h07;

endpackage
`default_nettype wire

>>> rtl/tcw_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_if: text console writer channel interfaces
// Request channel (operation, character, cell index) and response channel
// (cursor, cell word, echo), each with valid/ready.
// ---------------------------------------------------------------------------
interface tcw_req_if;
  logic                 valid;
  logic                 ready;
  tcw_pkg::opcode_t     opcode;
  tcw_pkg::char_t       char_code;
  tcw_pkg::cell_index_t cell_index;

  modport source (output valid, output opcode, output char_code, output cell_index,
                  input ready);
  modport sink   (input valid, input opcode, input char_code, input cell_index,
                  output ready);
endinterface

interface tcw_rsp_if;
  logic                    valid;
  logic                    ready;
  tcw_pkg::cursor_col_t    cursor_col;
  tcw_pkg::cursor_row_t    cursor_row;
  tcw_pkg::cursor_offset_t cursor_offset;
  tcw_pkg::cell_t          cell_value;
  logic                    echo_valid;
  tcw_pkg::char_t          echo_byte;

  modport source (output valid, output cursor_col, output cursor_row,
                  output cursor_offset, output cell_value, output echo_valid,
                  output echo_byte, input ready);
  modport sink   (input valid, input cursor_col, input cursor_row,
                  input cursor_offset, input cell_value, input echo_valid,
                  input echo_byte, output ready);
endinterface
`default_nettype wire

>>> rtl/text_console_writer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// text_console_writer: text-mode console engine
// Screen store of ROWS x COLUMNS cells in one synchronous RAM, a cursor,
// put-character, clear and read operations, one response word per request.
// ---------------------------------------------------------------------------
// Flow: a request word is taken in ST_IDLE and carried out in ST_EXEC; a
// cell read then registers the RAM word in ST_RDATA, and ST_DONE registers
// the response word once the response register is free. req.ready is low
// until then. A scroll moves or blanks one RAM cell per cycle, ROWS*COLUMNS
// cells in all; a clear blanks all ROWS*COLUMNS cells.
// Reset: after rst the RAM clearing pass writes all ROWS*COLUMNS cells (2000
// at 80x25) with req.ready low; configuration writes are taken meanwhile.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  tcw_pkg::attr_t cfg_wdata,
  tcw_req_if.sink        req,
  tcw_rsp_if.source      rsp
);
  import tcw_pkg::*;

  localparam int CELLS       = ROWS * COLUMNS;
  localparam int AW          = $clog2(CELLS);
  localparam int CW          = $clog2(COLUMNS);
  localparam int RW          = $clog2(ROWS);
  localparam int SCROLL_LAST = (ROWS - 1) * COLUMNS - 1;

  typedef enum logic [6:0] {
    ST_INIT   = 7'b0000001,
    ST_IDLE   = 7'b0000010,
    ST_EXEC   = 7'b0000100,
    ST_RDATA  = 7'b0001000,
    ST_SCROLL = 7'b0010000,
    ST_BLANK  = 7'b0100000,
    ST_DONE   = 7'b1000000
  } state_t;

  state_t      state;
  opcode_t     op_q;
  char_t       ch_q;
  cell_index_t idx_q;
  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [AW-1:0] cnt;
  attr_t       attr;
  cell_t       cell_q;
  logic        echo_v;
  char_t       echo_b;
  logic        out_valid;

  cell_t       screen [CELLS];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  cell_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  cell_t         mem_rdata;

  logic [AW-1:0] cur_addr;
  logic [AW-1:0] bs_addr;
  logic          col_last;
  logic          row_last;
  logic          is_nl;
  logic          is_bs;
  logic          wrap_scroll;
  cell_t         blank;

  assign cur_addr    = AW'(32'(row) * COLUMNS + 32'(col));
  assign bs_addr     = cur_addr - AW'(1);
  assign col_last    = (32'(col) == COLUMNS - 1);
  assign row_last    = (32'(row) == ROWS - 1);
  assign is_nl       = (ch_q == CH_NEWLINE);
  assign is_bs       = (ch_q == CH_BACKSPACE);
  assign wrap_scroll = (op_q == OP_PUT) && row_last && (is_nl || (!is_bs && col_last));
  assign blank       = {attr, CH_BLANK};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt;
    mem_wdata = blank;
    mem_raddr = AW'(idx_q);
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, CH_BLANK};
      end
      ST_EXEC: begin
        if (op_q == OP_PUT) begin
          if (is_bs) begin
            if (col != '0) begin
              mem_we    = 1'b1;
              mem_waddr = bs_addr;
            end
          end else if (!is_nl) begin
            mem_we    = 1'b1;
            mem_waddr = cur_addr;
            mem_wdata = {attr, ch_q};
          end
        end
        if (wrap_scroll) begin
          mem_raddr = AW'(COLUMNS);
        end
      end
      ST_SCROLL: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
        if (32'(cnt) == SCROLL_LAST) begin
          mem_raddr = '0;
        end else begin
          mem_raddr = AW'(32'(cnt) + COLUMNS + 1);
        end
      end
      ST_BLANK: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      screen[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= screen[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      cnt       <= '0;
      col       <= '0;
      row       <= '0;
      attr      <= RESET_ATTR;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          cnt <= cnt + AW'(1);
          if (32'(cnt) == CELLS - 1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (req.valid) begin
            op_q  <= req.opcode;
            ch_q  <= req.char_code;
            idx_q <= req.cell_index;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          cell_q <= '0;
          echo_v <= 1'b0;
          echo_b <= '0;
          state  <= ST_DONE;
          case (op_q)
            OP_PUT: begin
              if (is_nl) begin
                col <= '0;
                if (row_last) begin
                  cnt   <= '0;
                  state <= ST_SCROLL;
                end else begin
                  row <= row + RW'(1);
                end
              end else if (is_bs) begin
                if (col != '0) begin
                  col <= col - CW'(1);
                end
              end else begin
                echo_v <= 1'b1;
                echo_b <= ch_q;
                if (col_last) begin
                  col <= '0;
                  if (row_last) begin
                    cnt   <= '0;
                    state <= ST_SCROLL;
                  end else begin
                    row <= row + RW'(1);
                  end
                end else begin
                  col <= col + CW'(1);
                end
              end
            end
            OP_CLEAR: begin
              col   <= '0;
              row   <= '0;
              cnt   <= '0;
              state <= ST_BLANK;
            end
            OP_READ: begin
              if (32'(idx_q) < CELLS) begin
                state <= ST_RDATA;
              end
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_RDATA: begin
          cell_q <= mem_rdata;
          state  <= ST_DONE;
        end
        ST_SCROLL: begin
          cnt <= cnt + AW'(1);
          if (32'(cnt) == SCROLL_LAST) begin
            state <= ST_BLANK;
          end
        end
        ST_BLANK: begin
          if (32'(cnt) == CELLS - 1) begin
            state <= ST_DONE;
          end else begin
            cnt <= cnt + AW'(1);
          end
        end
        ST_DONE: begin
          if (!out_valid || rsp.ready) begin
            rsp.cursor_col    <= 7'(col);
            rsp.cursor_row    <= 5'(row);
            rsp.cursor_offset <= 11'(32'(row) * COLUMNS + 32'(col));
            rsp.cell_value    <= cell_q;
            rsp.echo_valid    <= echo_v;
            rsp.echo_byte     <= echo_b;
            out_valid         <= 1'b1;
            state             <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
        end
      endcase
    end
  end

  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;

endmodule
`default_nettype wire

>>> rtl/tcw_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tcw_checker: port-level checks for the text console writer
// Watches the request and response channels and the cursor fields.
// ---------------------------------------------------------------------------
module tcw_checker #(
  parameter int COLUMNS = 80
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        req_valid,
  input wire logic        req_ready,
  input wire logic        rsp_valid,
  input wire logic        rsp_ready,
  input wire logic [6:0]  cursor_col,
  input wire logic [4:0]  cursor_row,
  input wire logic [10:0] cursor_offset,
  input wire logic [15:0] cell_value,
  input wire logic        echo_valid
);

  a_init_blocks: assert property (@(posedge clk) rst |=> !req_ready)
    else $error("request taken right after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken while one is in work");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(cursor_offset)))
    else $error("stalled response dropped or changed");

  a_offset: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (cursor_offset == 11'(32'(cursor_row) * COLUMNS + 32'(cursor_col))))
    else $error("cursor offset does not match row and column");

  a_echo_no_cell: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && echo_valid) |-> (cell_value == 16'd0))
    else $error("echo response carries a cell word");

endmodule

bind text_console_writer tcw_checker #(.COLUMNS(COLUMNS)) u_tcw_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .cursor_col    (rsp.cursor_col),
  .cursor_row    (rsp.cursor_row),
  .cursor_offset (rsp.cursor_offset),
  .cell_value    (rsp.cell_value),
  .echo_valid    (rsp.echo_valid)
);
`default_nettype wire

>>> test/console_shadow_check.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// console_shadow_check: shadow screen and cursor for the console writer
// Watches the request and response channels and the attribute register
// port. Keeps its own copy of the screen, the cursor and the attribute, and
// works out the word each accepted request should produce. Compares every
// accepted response word, field by field, with the oldest pending word.
// ---------------------------------------------------------------------------
module console_shadow_check #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  tcw_pkg::attr_t cfg_wdata,
  tcw_req_if             req,
  tcw_rsp_if             rsp,
  output int             mismatches,
  output int             pending_words
);
  import tcw_pkg::*;

  localparam int CELLS = ROWS * COLUMNS;

  typedef struct packed {
    cursor_col_t    cursor_col;
    cursor_row_t    cursor_row;
    cursor_offset_t cursor_offset;
    cell_t          cell_value;
    logic           echo_valid;
    char_t          echo_byte;
  } console_word_t;

  cell_t         screen [CELLS];
  int            col_pos;
  int            row_pos;
  attr_t         text_attr;
  console_word_t expected_words [$];

  initial begin
    mismatches    = 0;
    pending_words = 0;
  end

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void next_line();
    col_pos = 0;
    if (row_pos < ROWS - 1) begin
      row_pos++;
    end else begin
      for (int i = 0; i < (ROWS - 1) * COLUMNS; i++) screen[i] = screen[i + COLUMNS];
      for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++) screen[i] = {text_attr, CH_BLANK};
    end
  endfunction

  function automatic console_word_t console_step(opcode_t op, char_t ch, cell_index_t idx);
    console_word_t w;
    w = '0;
    case (op)
      OP_PUT: begin
        if (ch == CH_NEWLINE) begin
          next_line();
        end else if (ch == CH_BACKSPACE) begin
          if (col_pos > 0) begin
            col_pos--;
            screen[row_pos * COLUMNS + col_pos] = {text_attr, CH_BLANK};
          end
        end else begin
          screen[row_pos * COLUMNS + col_pos] = {text_attr, ch};
          col_pos++;
          if (col_pos >= COLUMNS) next_line();
          w.echo_valid = 1'b1;
          w.echo_byte  = ch;
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) screen[i] = {text_attr, CH_BLANK};
        col_pos = 0;
        row_pos = 0;
      end
      OP_READ: begin
        if (idx < CELLS) w.cell_value = screen[idx];
      end
      default: ;
    endcase
    w.cursor_col    = cursor_col_t'(col_pos);
    w.cursor_row    = cursor_row_t'(row_pos);
    w.cursor_offset = cursor_offset_t'(row_pos * COLUMNS + col_pos);
    return w;
  endfunction

  always @(posedge clk) begin : watch
    console_word_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) screen[i] = {RESET_ATTR, CH_BLANK};
      col_pos   = 0;
      row_pos   = 0;
      text_attr = RESET_ATTR;
      expected_words.delete();
    end else begin
      if (cfg_we) text_attr = cfg_wdata;
      if (rsp.valid && rsp.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("response word with none pending");
        end else begin
          want = expected_words.pop_front();
          if (rsp.cursor_col !== want.cursor_col)
            report_mismatch($sformatf("cursor_col got %0d expected %0d",
                                      rsp.cursor_col, want.cursor_col));
          if (rsp.cursor_row !== want.cursor_row)
            report_mismatch($sformatf("cursor_row got %0d expected %0d",
                                      rsp.cursor_row, want.cursor_row));
          if (rsp.cursor_offset !== want.cursor_offset)
            report_mismatch($sformatf("cursor_offset got %0d expected %0d",
                                      rsp.cursor_offset, want.cursor_offset));
          if (rsp.cell_value !== want.cell_value)
            report_mismatch($sformatf("cell_value got %h expected %h",
                                      rsp.cell_value, want.cell_value));
          if (rsp.echo_valid !== want.echo_valid)
            report_mismatch($sformatf("echo_valid got %b expected %b",
                                      rsp.echo_valid, want.echo_valid));
          if (rsp.echo_byte !== want.echo_byte)
            report_mismatch($sformatf("echo_byte got %h expected %h",
                                      rsp.echo_byte, want.echo_byte));
        end
      end
      if (req.valid && req.ready)
        expected_words.push_back(console_step(req.opcode, req.char_code, req.cell_index));
    end
    pending_words <= expected_words.size();
  end

endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: text console writer
// Drives put-character, clear, read and unused requests in bursts with
// random gaps, first a short directed list and then phases of random
// sequences (text lines, wrapping runs, edits, newline floods, reads,
// clears, noise) under several attribute settings. The response side
// stalls on its own pattern and holds off at length at times. A shadow
// checker predicts and compares every response word.
// ---------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int      COLUMNS       = 80;
  localparam int      ROWS          = 25;
  localparam int      CELLS         = ROWS * COLUMNS;
  localparam int      PHASES        = 5;
  localparam int      PHASE_WORDS   = 120;
  localparam int      SETTLE_CYCLES = 2 * CELLS + 16;
  localparam int      IDLE_LIMIT    = 20000;
  localparam int      LONG_HOLD     = 300;
  localparam opcode_t OP_UNUSED     = 2'd3;

  logic  clk       = 1'b0;
  logic  rst       = 1'b1;
  logic  cfg_we    = 1'b0;
  attr_t cfg_wdata = RESET_ATTR;
  int    mismatches;
  int    pending_words;
  int    words_sent   = 0;
  int    burst_left   = 0;
  int    idle_cycles  = 0;
  int    rsp_mode     = 0;
  int    rsp_mode_left = 0;
  int    hold_left    = 0;
  int    rsp_taken    = 0;
  int    next_hold_at = 120;
  attr_t phase_attrs [PHASES];

  tcw_req_if req ();
  tcw_rsp_if rsp ();

  text_console_writer #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .rsp       (rsp)
  );

  console_shadow_check #(.COLUMNS(COLUMNS), .ROWS(ROWS)) shadow (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .req           (req),
    .rsp           (rsp),
    .mismatches    (mismatches),
    .pending_words (pending_words)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic char_t pick_glyph();
    char_t c;
    do c = char_t'($urandom_range(0, 255));
    while (c == CH_NEWLINE || c == CH_BACKSPACE);
    return c;
  endfunction

  function automatic cell_index_t any_index();
    return cell_index_t'($urandom_range(0, 2047));
  endfunction

  task automatic send_word(opcode_t op, char_t ch, cell_index_t idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req.valid      <= 1'b1;
    req.opcode     <= op;
    req.char_code  <= ch;
    req.cell_index <= idx;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_attribute(attr_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_directed();
    send_word(OP_READ, 8'h00, 11'd0);
    send_word(OP_READ, 8'hFF, 11'd1999);
    send_word(OP_READ, 8'h00, 11'd2000);
    send_word(OP_READ, 8'h00, 11'd2047);
    send_word(OP_PUT, CH_BACKSPACE, 11'd0);
    send_word(OP_PUT, 8'h00, 11'd2047);
    send_word(OP_PUT, 8'hFF, 11'd0);
    send_word(OP_PUT, 8'h41, 11'd1024);
    send_word(OP_PUT, CH_BACKSPACE, 11'd0);
    send_word(OP_READ, 8'h00, 11'd2);
    send_word(OP_READ, 8'h00, 11'd1);
    send_word(OP_PUT, CH_NEWLINE, 11'd0);
    send_word(OP_UNUSED, 8'hA5, 11'd1);
    send_word(OP_PUT, 8'h7F, 11'd0);
    send_word(OP_READ, 8'h00, 11'd80);
    send_word(OP_CLEAR, 8'h41, 11'd80);
    send_word(OP_READ, 8'h00, 11'd1);
    send_word(OP_READ, 8'h00, 11'd80);
    send_word(OP_PUT, CH_BACKSPACE, 11'd0);
    send_word(OP_UNUSED, CH_NEWLINE, 11'd2047);
    send_word(OP_READ, 8'h00, 11'd0);
  endtask

  task automatic run_random(int words);
    int target;
    int kind;
    int n;
    target = words_sent + words;
    while (words_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        n = $urandom_range(0, 30);
        repeat (n) send_word(OP_PUT, pick_glyph(), any_index());
        send_word(OP_PUT, CH_NEWLINE, any_index());
      end else if (kind < 39) begin
        n = $urandom_range(60, 170);
        repeat (n) send_word(OP_PUT, pick_glyph(), any_index());
      end else if (kind < 52) begin
        n = $urandom_range(0, 6);
        repeat (n) send_word(OP_PUT, pick_glyph(), any_index());
        n = $urandom_range(1, 10);
        repeat (n) send_word(OP_PUT, CH_BACKSPACE, any_index());
      end else if (kind < 68) begin
        n = $urandom_range(1, 6);
        repeat (n) begin
          if ($urandom_range(0, 3) == 0)
            send_word(OP_READ, char_t'($urandom_range(0, 255)),
                      cell_index_t'($urandom_range(CELLS, 2047)));
          else
            send_word(OP_READ, char_t'($urandom_range(0, 255)),
                      cell_index_t'($urandom_range(0, CELLS - 1)));
        end
      end else if (kind < 74) begin
        n = $urandom_range(3, 30);
        repeat (n) send_word(OP_PUT, CH_NEWLINE, any_index());
      end else if (kind < 77) begin
        send_word(OP_CLEAR, char_t'($urandom_range(0, 255)), any_index());
      end else begin
        n = $urandom_range(1, 8);
        repeat (n)
          send_word(opcode_t'($urandom_range(0, 3)), char_t'($urandom_range(0, 255)),
                    any_index());
      end
    end
  endtask

  initial begin
    req.valid      = 1'b0;
    req.opcode     = OP_PUT;
    req.char_code  = 8'h00;
    req.cell_index = 11'd0;
    rsp.ready      = 1'b0;
    phase_attrs[0] = 8'h00;
    phase_attrs[1] = 8'hFF;
    phase_attrs[2] = attr_t'($urandom_range(0, 255));
    phase_attrs[3] = attr_t'($urandom_range(0, 255));
    phase_attrs[4] = RESET_ATTR;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_attribute(phase_attrs[ph]);
      run_random(PHASE_WORDS);
    end
    settle();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // hold off at length now and then, otherwise stall on a changing duty pattern
  always @(posedge clk) begin
    if (rsp.valid && rsp.ready) rsp_taken++;
    if (rsp_mode_left == 0) begin
      rsp_mode      = $urandom_range(0, 3);
      rsp_mode_left = $urandom_range(10, 150);
    end else begin
      rsp_mode_left--;
    end
    if (hold_left == 0 && rsp_taken == next_hold_at) begin
      hold_left    = LONG_HOLD;
      next_hold_at = next_hold_at + 250;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp.ready <= 1'b0;
    end else begin
      case (rsp_mode)
        0:       rsp.ready <= 1'b1;
        1:       rsp.ready <= ($urandom_range(0, 1) == 0);
        2:       rsp.ready <= ($urandom_range(0, 3) == 0);
        default: rsp.ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
